FILE: sv/btpc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// btpc_pkg: shared constants and types
// Field widths, calibration register indexes and compensation constants for
// the barometric temperature and pressure compensation block.
// ----------------------------------------------------------------------------
package btpc_pkg;

	localparam int RAW_W     = 20;
	localparam int TEMP_W    = 16;
	localparam int PRESS_W   = 32;
	localparam int CAL_W     = 32;
	localparam int CAL_REGS  = 6;
	localparam int CFG_IDX_W = 3;

	// calibration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_T1_T2 = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_T3_P1 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_P2_P3 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_P4_P5 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_P6_P7 = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_P8_P9 = 3'd5;

	// compensation constants
	localparam int FINE_W      = 26;       // fine temperature, signed
	localparam int FINE_OFFSET = 128000;
	localparam int FULL_SCALE  = 1048576;
	localparam int DIV_SCALE   = 3125;
	localparam int P4_SHIFT    = 35;
	localparam int DIV_BITS    = 64;       // quotient bits, one per divider stage
	localparam int DEN_W       = 31;       // divisor magnitude width

	typedef logic [CAL_W-1:0] cal_word_t;

endpackage
`default_nettype wire

FILE: sv/btpc_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// btpc interfaces
// Valid/ready channels for raw samples, compensated results and calibration
// register writes.
// ----------------------------------------------------------------------------
interface btpc_sample_if;
	import btpc_pkg::*;
	logic              valid;
	logic              ready;
	logic [RAW_W-1:0]  raw_temperature;
	logic [RAW_W-1:0]  raw_pressure;
	modport source (output valid, raw_temperature, raw_pressure, input ready);
	modport sink   (input valid, raw_temperature, raw_pressure, output ready);
endinterface

interface btpc_result_if;
	import btpc_pkg::*;
	logic                      valid;
	logic                      ready;
	logic signed [TEMP_W-1:0]  temperature_centi;
	logic [PRESS_W-1:0]        pressure_q24_8;
	logic                      pressure_valid;
	modport source (output valid, temperature_centi, pressure_q24_8, pressure_valid,
		input ready);
	modport sink   (input valid, temperature_centi, pressure_q24_8, pressure_valid,
		output ready);
endinterface

interface btpc_cfg_if;
	import btpc_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CAL_W-1:0]      data;
	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

FILE: sv/baro_temp_press_compensation.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// baro_temp_press_compensation: integer temperature/pressure compensation
// Fine temperature, saturated centidegree output and the 64-bit pressure
// polynomial with a pipelined radix-2 signed divider.
// ----------------------------------------------------------------------------
// Usage: write the six calibration words through cfg (always ready, index 0..5,
// other indexes ignored) while no sample is in flight, then stream sample words.
// The datapath is a 79-stage pipeline: ten stages of fine temperature and
// pressure polynomial, 64 restoring-divider stages (one quotient bit each, a
// 32-bit compare/subtract per stage) and five stages of the final correction
// terms, followed by an output register with a one-word skid buffer. One
// sample word is accepted every clock while the skid word is empty; a result
// word passes through every stage and the output register. While result.ready
// is low the whole pipeline holds once the skid word is occupied, so nothing is
// lost or repeated. A zero divisor (P1 zero, as after reset) gives pressure 0
// with pressure_valid low; the temperature is always produced.
module baro_temp_press_compensation (
	input  wire logic        clk,
	input  wire logic        arst_n,
	btpc_sample_if.sink      sample,
	btpc_result_if.source    result,
	btpc_cfg_if.sink         cfg
);
	import btpc_pkg::*;

	localparam int PW = FINE_W + 1;   // fine minus offset

	// ------------------------------------------------------------------
	// calibration registers
	// ------------------------------------------------------------------
	cal_word_t cal_q [CAL_REGS];

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CAL_REGS; i++) cal_q[i] <= '0;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_T1_T2: cal_q[REG_T1_T2] <= cfg.data;
				REG_T3_P1: cal_q[REG_T3_P1] <= cfg.data;
				REG_P2_P3: cal_q[REG_P2_P3] <= cfg.data;
				REG_P4_P5: cal_q[REG_P4_P5] <= cfg.data;
				REG_P6_P7: cal_q[REG_P6_P7] <= cfg.data;
				REG_P8_P9: cal_q[REG_P8_P9] <= cfg.data;
				default: ;
			endcase
		end
	end

	logic        [15:0] t1, p1;
	logic signed [15:0] t2, t3, p2, p3, p4, p5, p6, p7, p8, p9;

	assign t1 = cal_q[REG_T1_T2][15:0];
	assign t2 = $signed(cal_q[REG_T1_T2][31:16]);
	assign t3 = $signed(cal_q[REG_T3_P1][15:0]);
	assign p1 = cal_q[REG_T3_P1][31:16];
	assign p2 = $signed(cal_q[REG_P2_P3][15:0]);
	assign p3 = $signed(cal_q[REG_P2_P3][31:16]);
	assign p4 = $signed(cal_q[REG_P4_P5][15:0]);
	assign p5 = $signed(cal_q[REG_P4_P5][31:16]);
	assign p6 = $signed(cal_q[REG_P6_P7][15:0]);
	assign p7 = $signed(cal_q[REG_P6_P7][31:16]);
	assign p8 = $signed(cal_q[REG_P8_P9][15:0]);
	assign p9 = $signed(cal_q[REG_P8_P9][31:16]);

	// global advance: the pipeline moves unless the skid word is occupied
	logic adv;
	logic skid_v_q;
	assign adv = !skid_v_q;
	assign sample.ready = adv;

	// ------------------------------------------------------------------
	// s1: temperature differences and first products
	// ------------------------------------------------------------------
	logic signed [17:0] ta_c;
	logic signed [16:0] tb_c;
	logic signed [33:0] ma_c, bb_c;

	always_comb begin
		ta_c = $signed({1'b0, sample.raw_temperature[RAW_W-1:3]}) - $signed({1'b0, t1, 1'b0});
		tb_c = $signed({1'b0, sample.raw_temperature[RAW_W-1:4]}) - $signed({1'b0, t1});
		ma_c = ta_c * t2;
		bb_c = tb_c * tb_c;
	end

	logic               v_s1;
	logic signed [33:0] ma_s1;
	logic        [31:0] bb_s1;
	logic [RAW_W-1:0]   adcp_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (adv) v_s1 <= sample.valid;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ma_s1   <= ma_c;
			bb_s1   <= bb_c[31:0];     // square is below 2^32
			adcp_s1 <= sample.raw_pressure;
		end
	end

	// ------------------------------------------------------------------
	// s2: var1 and the T3 product
	// ------------------------------------------------------------------
	logic signed [36:0] m3_c;
	assign m3_c = $signed({1'b0, bb_s1[31:12]}) * t3;

	logic               v_s2;
	logic signed [22:0] v1t_s2;
	logic signed [36:0] m3_s2;
	logic [RAW_W-1:0]   adcp_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (adv) v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			v1t_s2  <= $signed(ma_s1[33:11]);
			m3_s2   <= m3_c;
			adcp_s2 <= adcp_s1;
		end
	end

	// ------------------------------------------------------------------
	// s3: fine temperature
	// ------------------------------------------------------------------
	logic signed [FINE_W-1:0] fine_c;
	assign fine_c = FINE_W'(v1t_s2) + FINE_W'($signed(m3_s2[36:14]));

	logic                     v_s3;
	logic signed [FINE_W-1:0] fine_s3;
	logic [RAW_W-1:0]         adcp_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (adv) v_s3 <= v_s2;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			fine_s3 <= fine_c;
			adcp_s3 <= adcp_s2;
		end
	end

	// ------------------------------------------------------------------
	// s4: centidegree output with saturation, pressure var1
	// ------------------------------------------------------------------
	logic signed [FINE_W+2:0] t5_c;
	logic signed [FINE_W-6:0] ts_c;
	logic signed [TEMP_W-1:0] tsat_c;
	logic signed [PW-1:0]     pv1_c;

	always_comb begin
		t5_c = fine_s3 * 29'sd5 + 29'sd128;
		ts_c = $signed(t5_c[FINE_W+2:8]);
		if (ts_c > 21'sd32767)
			tsat_c = 16'sh7FFF;
		else if (ts_c < -21'sd32768)
			tsat_c = 16'sh8000;
		else
			tsat_c = ts_c[TEMP_W-1:0];
		pv1_c = PW'(fine_s3) - PW'(FINE_OFFSET);
	end

	logic                     v_s4;
	logic signed [TEMP_W-1:0] temp_s4;
	logic signed [PW-1:0]     pv1_s4;
	logic [RAW_W-1:0]         adcp_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else if (adv) v_s4 <= v_s3;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			temp_s4 <= tsat_c;
			pv1_s4  <= pv1_c;
			adcp_s4 <= adcp_s3;
		end
	end

	// ------------------------------------------------------------------
	// s5: square of var1 and the P5/P2 products
	// ------------------------------------------------------------------
	logic                     v_s5;
	logic signed [2*PW-1:0]   vv_s5;
	logic signed [PW+15:0]    m5_s5, m2_s5;
	logic signed [TEMP_W-1:0] temp_s5;
	logic [RAW_W-1:0]         adcp_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s5 <= 1'b0;
		else if (adv) v_s5 <= v_s4;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			vv_s5   <= pv1_s4 * pv1_s4;
			m5_s5   <= pv1_s4 * p5;
			m2_s5   <= pv1_s4 * p2;
			temp_s5 <= temp_s4;
			adcp_s5 <= adcp_s4;
		end
	end

	// ------------------------------------------------------------------
	// s6: square times P6 and P3, low 64 bits
	// ------------------------------------------------------------------
	logic signed [2*PW+15:0] x6_c, x3_c;
	assign x6_c = vv_s5 * p6;
	assign x3_c = vv_s5 * p3;

	logic                     v_s6;
	logic [63:0]              x6_s6, x3_s6;
	logic signed [PW+15:0]    m5_s6, m2_s6;
	logic signed [TEMP_W-1:0] temp_s6;
	logic [RAW_W-1:0]         adcp_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s6 <= 1'b0;
		else if (adv) v_s6 <= v_s5;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			x6_s6   <= x6_c[63:0];
			x3_s6   <= x3_c[63:0];
			m5_s6   <= m5_s5;
			m2_s6   <= m2_s5;
			temp_s6 <= temp_s5;
			adcp_s6 <= adcp_s5;
		end
	end

	// ------------------------------------------------------------------
	// s7: var2 and var1 sums (64-bit wrap), var1 gets the 2^47 offset
	// ------------------------------------------------------------------
	logic [63:0] v2_c, v1b_c;

	always_comb begin
		v2_c = x6_s6
			+ ({{(64-PW-16){m5_s6[PW+15]}}, m5_s6} << 17)
			+ ({{48{p4[15]}}, p4} << P4_SHIFT);
		v1b_c = {{8{x3_s6[63]}}, x3_s6[63:8]}
			+ ({{(64-PW-16){m2_s6[PW+15]}}, m2_s6} << 12)
			+ (64'd1 << 47);
	end

	logic                     v_s7;
	logic [63:0]              v2_s7, v1b_s7;
	logic signed [TEMP_W-1:0] temp_s7;
	logic [RAW_W-1:0]         adcp_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s7 <= 1'b0;
		else if (adv) v_s7 <= v_s6;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			v2_s7   <= v2_c;
			v1b_s7  <= v1b_c;
			temp_s7 <= temp_s6;
			adcp_s7 <= adcp_s6;
		end
	end

	// ------------------------------------------------------------------
	// s8: P1 partial products, numerator base
	// ------------------------------------------------------------------
	logic [RAW_W:0]  pd_c;
	logic [63:0]     pn_c;
	logic [47:0]     lo_c, hi_c;

	always_comb begin
		pd_c = (RAW_W+1)'(FULL_SCALE) - {1'b0, adcp_s7};
		pn_c = ({{(63-RAW_W){1'b0}}, pd_c} << 31) - v2_s7;
		lo_c = v1b_s7[31:0] * p1;
		hi_c = v1b_s7[63:32] * p1;
	end

	logic                     v_s8;
	logic [63:0]              pn_s8;
	logic [47:0]              lo_s8;
	logic [31:0]              hi_s8;
	logic signed [TEMP_W-1:0] temp_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s8 <= 1'b0;
		else if (adv) v_s8 <= v_s7;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pn_s8   <= pn_c;
			lo_s8   <= lo_c;
			hi_s8   <= hi_c[31:0];
			temp_s8 <= temp_s7;
		end
	end

	// ------------------------------------------------------------------
	// s9: divisor (product >>> 33) and scaled numerator
	// ------------------------------------------------------------------
	logic [63:0] prod_c, num_c;

	always_comb begin
		prod_c = {16'd0, lo_s8} + {hi_s8, 32'd0};
		num_c  = pn_s8 * 64'(DIV_SCALE);
	end

	logic                     v_s9;
	logic [DEN_W-1:0]         den_s9;
	logic [63:0]              num_s9;
	logic signed [TEMP_W-1:0] temp_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s9 <= 1'b0;
		else if (adv) v_s9 <= v_s8;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			den_s9  <= prod_c[63:33];
			num_s9  <= num_c;
			temp_s9 <= temp_s8;
		end
	end

	// ------------------------------------------------------------------
	// s10 and divider: magnitudes enter slot 0, one quotient bit per stage
	// ------------------------------------------------------------------
	logic                     div_v_s    [0:DIV_BITS];
	logic [DEN_W-1:0]         div_rem_s  [0:DIV_BITS];
	logic [63:0]              div_num_s  [0:DIV_BITS];
	logic [DEN_W-1:0]         div_den_s  [0:DIV_BITS];
	logic                     div_neg_s  [0:DIV_BITS];
	logic                     div_zero_s [0:DIV_BITS];
	logic signed [TEMP_W-1:0] div_temp_s [0:DIV_BITS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) div_v_s[0] <= 1'b0;
		else if (adv) div_v_s[0] <= v_s9;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			div_rem_s[0]  <= '0;
			div_num_s[0]  <= num_s9[63] ? (64'd0 - num_s9) : num_s9;
			div_den_s[0]  <= den_s9[DEN_W-1] ? (DEN_W'(0) - den_s9) : den_s9;
			div_neg_s[0]  <= num_s9[63] ^ den_s9[DEN_W-1];
			div_zero_s[0] <= (den_s9 == '0);
			div_temp_s[0] <= temp_s9;
		end
	end

	for (genvar k = 0; k < DIV_BITS; k++) begin : g_div
		logic [DEN_W:0] trial;
		logic [DEN_W:0] diff;
		logic           ge;

		always_comb begin
			trial = {div_rem_s[k], div_num_s[k][63]};
			diff  = trial - {1'b0, div_den_s[k]};
			ge    = (trial >= {1'b0, div_den_s[k]});
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) div_v_s[k+1] <= 1'b0;
			else if (adv) div_v_s[k+1] <= div_v_s[k];
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				div_rem_s[k+1]  <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
				div_num_s[k+1]  <= {div_num_s[k][62:0], ge};
				div_den_s[k+1]  <= div_den_s[k];
				div_neg_s[k+1]  <= div_neg_s[k];
				div_zero_s[k+1] <= div_zero_s[k];
				div_temp_s[k+1] <= div_temp_s[k];
			end
		end
	end

	// ------------------------------------------------------------------
	// s11: signed quotient
	// ------------------------------------------------------------------
	logic                     v_s11;
	logic [63:0]              q_s11;
	logic                     zero_s11;
	logic signed [TEMP_W-1:0] temp_s11;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s11 <= 1'b0;
		else if (adv) v_s11 <= div_v_s[DIV_BITS];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			q_s11    <= div_neg_s[DIV_BITS] ? (64'd0 - div_num_s[DIV_BITS])
				: div_num_s[DIV_BITS];
			zero_s11 <= div_zero_s[DIV_BITS];
			temp_s11 <= div_temp_s[DIV_BITS];
		end
	end

	// ------------------------------------------------------------------
	// s12: P9 * (q >>> 13), P8 * q halves
	// ------------------------------------------------------------------
	logic [63:0]        sq11_c;
	logic signed [66:0] m9_c;
	logic signed [48:0] bl_c, bh_c;

	always_comb begin
		sq11_c = {{13{q_s11[63]}}, q_s11[63:13]};
		m9_c   = p9 * $signed(sq11_c[50:0]);
		bl_c   = p8 * $signed({1'b0, q_s11[31:0]});
		bh_c   = p8 * $signed({1'b0, q_s11[63:32]});
	end

	logic                     v_s12;
	logic [63:0]              q_s12, m9_s12;
	logic [48:0]              bl_s12;
	logic [31:0]              bh_s12;
	logic                     zero_s12;
	logic signed [TEMP_W-1:0] temp_s12;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s12 <= 1'b0;
		else if (adv) v_s12 <= v_s11;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			q_s12    <= q_s11;
			m9_s12   <= m9_c[63:0];
			bl_s12   <= bl_c;
			bh_s12   <= bh_c[31:0];
			zero_s12 <= zero_s11;
			temp_s12 <= temp_s11;
		end
	end

	// ------------------------------------------------------------------
	// s13: second multiply by (q >>> 13) as 32-bit partial products
	// ------------------------------------------------------------------
	logic [63:0] sq12_c, pp0_c, pp1_c, pp2_c, bsum_c;

	always_comb begin
		sq12_c = {{13{q_s12[63]}}, q_s12[63:13]};
		pp0_c  = m9_s12[31:0] * sq12_c[31:0];
		pp1_c  = m9_s12[31:0] * sq12_c[63:32];
		pp2_c  = m9_s12[63:32] * sq12_c[31:0];
		bsum_c = {{15{bl_s12[48]}}, bl_s12} + {bh_s12, 32'd0};
	end

	logic                     v_s13;
	logic [63:0]              q_s13, pp0_s13, b_s13;
	logic [31:0]              pp1_s13, pp2_s13;
	logic                     zero_s13;
	logic signed [TEMP_W-1:0] temp_s13;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s13 <= 1'b0;
		else if (adv) v_s13 <= v_s12;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			q_s13    <= q_s12;
			pp0_s13  <= pp0_c;
			pp1_s13  <= pp1_c[31:0];
			pp2_s13  <= pp2_c[31:0];
			b_s13    <= bsum_c;
			zero_s13 <= zero_s12;
			temp_s13 <= temp_s12;
		end
	end

	// ------------------------------------------------------------------
	// s14: assemble the P9 term
	// ------------------------------------------------------------------
	logic [31:0] mid_c;
	assign mid_c = pp1_s13 + pp2_s13;

	logic                     v_s14;
	logic [63:0]              q_s14, a_s14, b_s14;
	logic                     zero_s14;
	logic signed [TEMP_W-1:0] temp_s14;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s14 <= 1'b0;
		else if (adv) v_s14 <= v_s13;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			q_s14    <= q_s13;
			a_s14    <= pp0_s13 + {mid_c, 32'd0};
			b_s14    <= b_s13;
			zero_s14 <= zero_s13;
			temp_s14 <= temp_s13;
		end
	end

	// ------------------------------------------------------------------
	// s15: final sum, >>> 8, plus P7 << 4; only the low 32 bits leave
	// ------------------------------------------------------------------
	logic [63:0] sum_c;
	logic [31:0] pr_c;

	always_comb begin
		sum_c = q_s14 + {{25{a_s14[63]}}, a_s14[63:25]} + {{19{b_s14[63]}}, b_s14[63:19]};
		pr_c  = sum_c[39:8] + {{12{p7[15]}}, p7, 4'd0};
	end

	logic                     v_s15;
	logic [PRESS_W-1:0]       press_s15;
	logic                     pv_s15;
	logic signed [TEMP_W-1:0] temp_s15;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s15 <= 1'b0;
		else if (adv) v_s15 <= v_s14;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			press_s15 <= zero_s14 ? '0 : pr_c;
			pv_s15    <= !zero_s14;
			temp_s15  <= temp_s14;
		end
	end

	// ------------------------------------------------------------------
	// output register and skid word
	// ------------------------------------------------------------------
	logic                     out_v_q;
	logic signed [TEMP_W-1:0] out_temp_q, skid_temp_q;
	logic [PRESS_W-1:0]       out_press_q, skid_press_q;
	logic                     out_pv_q, skid_pv_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (result.ready) skid_v_q <= 1'b0;
		end else if (v_s15) begin
			if (!out_v_q || result.ready) out_v_q <= 1'b1;
			else skid_v_q <= 1'b1;
		end else if (result.ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (result.ready) begin
				out_temp_q  <= skid_temp_q;
				out_press_q <= skid_press_q;
				out_pv_q    <= skid_pv_q;
			end
		end else if (v_s15) begin
			if (!out_v_q || result.ready) begin
				out_temp_q  <= temp_s15;
				out_press_q <= press_s15;
				out_pv_q    <= pv_s15;
			end else begin
				skid_temp_q  <= temp_s15;
				skid_press_q <= press_s15;
				skid_pv_q    <= pv_s15;
			end
		end
	end

	assign result.valid             = out_v_q;
	assign result.temperature_centi = out_temp_q;
	assign result.pressure_q24_8    = out_press_q;
	assign result.pressure_valid    = out_pv_q;

endmodule
`default_nettype wire

FILE: sv/btpc_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// btpc_checker: port-level assertions
// Checks stall behavior, zero-divisor output, back-pressure and config ready on the ports.
// ----------------------------------------------------------------------------
module btpc_checker (
	input wire logic                           clk,
	input wire logic                           arst_n,
	input wire logic                           in_ready,
	input wire logic                           out_valid,
	input wire logic                           out_ready,
	input wire logic signed [btpc_pkg::TEMP_W-1:0] temperature,
	input wire logic [btpc_pkg::PRESS_W-1:0]   pressure,
	input wire logic                           pvalid,
	input wire logic                           cfg_valid,
	input wire logic                           cfg_ready
);
	import btpc_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(temperature)
			&& $stable(pressure) && $stable(pvalid))
		else $error("result word changed while stalled");

	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !pvalid |-> pressure == '0)
		else $error("pressure nonzero with pressure_valid low");

	a_bp: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && $past(out_valid && !out_ready))
		else $error("input held off without an output stall");

	a_cfg: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("config write not taken");

endmodule

bind baro_temp_press_compensation btpc_checker u_btpc_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_ready    (sample.ready),
	.out_valid   (result.valid),
	.out_ready   (result.ready),
	.temperature (result.temperature_centi),
	.pressure    (result.pressure_q24_8),
	.pvalid      (result.pressure_valid),
	.cfg_valid   (cfg.valid),
	.cfg_ready   (cfg.ready)
);
`default_nettype wire
